FILE: hdl/sha256_pkg.sv
package sha256_pkg;

	// one input transfer: a message byte and its framing flags
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_item_t;

	// one output transfer: a word of the final digest
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_FOLD,
		ST_OUT
	} state_t;

	localparam int unsigned NUM_ROUNDS = 64;
	localparam logic [7:0]  PAD_MARK   = 8'h80;
	localparam logic [5:0]  LEN_POS    = 6'd56;
	localparam logic [5:0]  LAST_POS   = 6'd63;
	localparam logic [2:0]  LAST_IDX   = 3'd7;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

FILE: hdl/sha256_in_if.sv
interface sha256_in_if import sha256_pkg::*; ();

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

FILE: hdl/sha256_out_if.sv
interface sha256_out_if import sha256_pkg::*; ();

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

FILE: hdl/sha256_message_hasher.sv
// SHA-256 hasher for a byte stream. Each transfer on the message channel carries at most one
// byte; a transfer with end_of_message set closes the message (with or without a final byte),
// after which the eight digest words come out on the digest channel, word 0 first, and the
// hasher restarts from the initial hash. Every 64th byte starts a compression (64 rounds
// through one shared round unit, then a fold into the chaining hash); the message channel
// is not ready meanwhile. At end of message the padding is shifted into the block one byte
// per cycle, up to the end of the last block when n bytes of it were filled and n < 56, or
// through the end of that block and a whole further block when n >= 56, followed by one or
// two compressions and eight digest transfers. Sustained throughput is set by the single
// round unit.
module sha256_message_hasher import sha256_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	sha256_in_if.sink           message,
	sha256_out_if.source        digest
);

	// round helpers
	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	state_t       state_q, state_d;
	logic [5:0]   cnt_q;
	logic [63:0]  bits_q;
	logic [5:0]   rnd_q;
	logic [2:0]   oidx_q;
	logic         fin_q;
	logic         pad80_q;
	logic         len_ok_q;
	logic         last_blk_q;
	logic [31:0]  hash_q [8];
	logic [31:0]  wv_q [8];
	logic [511:0] blk_q;

	logic         shift_byte;
	logic [7:0]   byte_val;
	logic         add_bits;
	logic         len_byte;
	logic         start_comp;
	logic         do_round;
	logic         fold;
	logic         emit;
	logic         in_xfer;

	assign in_xfer = message.valid && message.ready;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath strobes
	always_comb begin
		state_d       = state_q;
		shift_byte    = 1'b0;
		byte_val      = 8'h00;
		add_bits      = 1'b0;
		len_byte      = 1'b0;
		start_comp    = 1'b0;
		do_round      = 1'b0;
		fold          = 1'b0;
		emit          = 1'b0;
		message.ready = 1'b0;
		digest.valid  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				message.ready = 1'b1;
				if (message.valid) begin
					if (message.data.byte_present) begin
						shift_byte = 1'b1;
						byte_val   = message.data.data_byte;
						add_bits   = 1'b1;
						if (cnt_q == LAST_POS) begin
							start_comp = 1'b1;
							state_d    = ST_COMP;
						end else if (message.data.end_of_message) begin
							state_d = ST_PAD;
						end
					end else if (message.data.end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				shift_byte = 1'b1;
				if (!pad80_q) begin
					byte_val = PAD_MARK;
				end else if (len_ok_q && (cnt_q >= LEN_POS)) begin
					byte_val = bits_q[63:56];
					len_byte = 1'b1;
				end
				if (cnt_q == LAST_POS) begin
					start_comp = 1'b1;
					state_d    = ST_COMP;
				end
			end
			ST_COMP: begin
				do_round = 1'b1;
				if (rnd_q == 6'(NUM_ROUNDS - 1)) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				fold = 1'b1;
				if (!fin_q) begin
					state_d = ST_IDLE;
				end else if (last_blk_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				digest.valid = 1'b1;
				if (digest.ready) begin
					emit = 1'b1;
					if (oidx_q == LAST_IDX) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// message framing, counters and padding flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			bits_q     <= '0;
			rnd_q      <= '0;
			oidx_q     <= '0;
			fin_q      <= 1'b0;
			pad80_q    <= 1'b0;
			len_ok_q   <= 1'b0;
			last_blk_q <= 1'b0;
		end else begin
			if (shift_byte) begin
				cnt_q <= cnt_q + 6'd1;
			end
			// length shifts out MSB first, leaving zero for the next message
			if (add_bits) begin
				bits_q <= bits_q + 64'd8;
			end else if (len_byte) begin
				bits_q <= {bits_q[55:0], 8'h00};
			end
			if (do_round) begin
				rnd_q <= rnd_q + 6'd1;
			end else begin
				rnd_q <= '0;
			end
			if (emit) begin
				oidx_q <= oidx_q + 3'd1;
			end
			if (in_xfer) begin
				fin_q      <= message.data.end_of_message;
				pad80_q    <= 1'b0;
				last_blk_q <= 1'b0;
			end
			if (state_q == ST_PAD) begin
				if (!pad80_q) begin
					pad80_q  <= 1'b1;
					len_ok_q <= (cnt_q < LEN_POS);
				end
				if (cnt_q == LAST_POS) begin
					last_blk_q <= pad80_q && len_ok_q;
				end
			end
			// a block after a compression always has room for the length
			if (fold) begin
				len_ok_q <= 1'b1;
			end
		end
	end

	// chaining hash: fold after each block, rotate out the digest and refill with the IV
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= INIT_HASH[i];
			end
		end else if (fold) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + wv_q[i];
			end
		end else if (emit) begin
			for (int i = 0; i < 7; i++) begin
				hash_q[i] <= hash_q[i + 1];
			end
			hash_q[7] <= INIT_HASH[oidx_q];
		end
	end

	// block window: bytes shift in big-endian; during rounds it holds W[t..t+15]
	always_ff @(posedge clk) begin
		if (shift_byte) begin
			blk_q <= {blk_q[503:0], byte_val};
		end else if (do_round) begin
			blk_q <= {blk_q[479:0],
				small_sigma1(blk_q[63:32]) + blk_q[223:192] +
				small_sigma0(blk_q[479:448]) + blk_q[511:480]};
		end
	end

	// shared round unit on the working variables a..h
	always_ff @(posedge clk) begin
		logic [31:0] t1;
		logic [31:0] t2;
		t1 = wv_q[7] + big_sigma1(wv_q[4]) + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
			+ ROUND_K[rnd_q] + blk_q[511:480];
		t2 = big_sigma0(wv_q[0])
			+ ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));
		if (start_comp) begin
			for (int i = 0; i < 8; i++) begin
				wv_q[i] <= hash_q[i];
			end
		end else if (do_round) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	// digest payload
	assign digest.data.digest_word = hash_q[0];
	assign digest.data.word_index  = oidx_q;
	assign digest.data.last_word   = (oidx_q == LAST_IDX);

`ifndef ASSERT_OFF
	// never take a byte while a digest is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(message.ready && digest.valid))
		else $error("message ready while digest valid");

	// after the final digest transfer the length and byte count are back at zero
	a_clean_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(digest.valid && digest.ready && digest.data.last_word) |=>
		(cnt_q == 6'd0 && bits_q == 64'd0 && state_q == ST_IDLE))
		else $error("hasher not cleared after digest");

	// a compression only runs on a complete block
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP) |-> (cnt_q == 6'd0))
		else $error("compression on partial block");
`endif

endmodule

FILE: test/tb.sv
module tb;
	import sha256_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int IDLE_PCT      = 34;
	localparam int RANDOM_ITEMS  = 270;
	localparam int HOLD_AFTER    = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 40;
	localparam int QUIET_FROM    = 160;
	localparam int QUIET_TO      = 230;
	localparam int NOISE_PCT     = 8;
	localparam int PAUSE_EVERY   = 4;
	localparam int LEN_FIELD_POS = 56;
	localparam int FINAL_WORD    = 7;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// message lengths around the padding split points
	localparam int BOUNDARY_LEN [8] = '{54, 55, 56, 57, 63, 64, 65, 119};

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// pending message item, or a marker that holds the sender until all digests are in
	typedef struct packed {
		logic     pause;
		in_item_t item;
	} feed_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sha256_in_if  message_ch ();
	sha256_out_if digest_ch ();

	sha256_message_hasher i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.message(message_ch),
		.digest (digest_ch)
	);

	feed_t       feed_q [$];
	out_item_t   digest_exp_q [$];

	// running hash state of the predictor
	logic [31:0] hash_st [8];
	logic [31:0] blk_w [16];
	logic [5:0]  blk_fill = '0;
	logic [63:0] msg_bits = '0;

	int   items_taken   = 0;
	int   bytes_hashed  = 0;
	int   msgs_closed   = 0;
	int   words_checked = 0;
	int   err_count     = 0;
	int   cyc           = 0;
	int   rx_hold_left  = 0;
	logic msg_xfer      = 1'b0;
	logic rx_holding    = 1'b0;
	logic rx_hold_done  = 1'b0;
	logic quiet;

	assign quiet = (items_taken >= QUIET_FROM) && (items_taken < QUIET_TO);

	always #5 clk = ~clk;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic place_byte(input int pos, input logic [7:0] val);
		blk_w[pos / 4][(3 - pos % 4) * 8 +: 8] = val;
	endtask

	// run one 64-round compression of the current block into the chaining hash
	task automatic compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int t = 0; t < 16; t++)
			w[t] = blk_w[t];
		for (int t = 16; t < 64; t++) begin
			s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = s1 + w[t-7] + s0 + w[t-16];
		end
		for (int i = 0; i < 8; i++)
			v[i] = hash_st[i];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_st[i] = hash_st[i] + v[i];
	endtask

	// absorb one accepted item; at end of message pad, finish and queue the digest words
	task automatic hash_item(input in_item_t it);
		out_item_t word;
		int        pos;
		if (it.byte_present) begin
			place_byte(blk_fill, it.data_byte);
			msg_bits = msg_bits + 64'd8;
			blk_fill = blk_fill + 6'd1;
			bytes_hashed++;
			if (blk_fill == '0)
				compress_block();
		end
		if (it.end_of_message) begin
			pos = blk_fill;
			place_byte(pos, PAD_BYTE);
			for (int p = pos + 1; p < 64; p++)
				place_byte(p, 8'h00);
			// no room for the length: flush this block and use a zero block
			if (pos >= LEN_FIELD_POS) begin
				compress_block();
				for (int k = 0; k < 16; k++)
					blk_w[k] = '0;
			end
			blk_w[14] = msg_bits[63:32];
			blk_w[15] = msg_bits[31:0];
			compress_block();
			for (int k = 0; k < 8; k++) begin
				word.digest_word = hash_st[k];
				word.word_index  = 3'(k);
				word.last_word   = (k == FINAL_WORD);
				digest_exp_q.push_back(word);
			end
			for (int k = 0; k < 8; k++)
				hash_st[k] = SHA_IV[k];
			blk_fill = '0;
			msg_bits = '0;
			msgs_closed++;
		end
	endtask

	task automatic queue_item(input logic [7:0] d, input logic present, input logic eom);
		feed_t f;
		f.pause               = 1'b0;
		f.item.data_byte      = d;
		f.item.byte_present   = present;
		f.item.end_of_message = eom;
		feed_q.push_back(f);
	endtask

	task automatic queue_pause();
		feed_t f;
		f       = '0;
		f.pause = 1'b1;
		feed_q.push_back(f);
	endtask

	// sample both channels on the rising edge: predict on input transfers, check outputs
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		cyc++;
		msg_xfer <= arst_n && message_ch.valid && message_ch.ready;
		if (arst_n && message_ch.valid && message_ch.ready) begin
			hash_item(message_ch.data);
			items_taken++;
		end
		if (arst_n && digest_ch.valid && digest_ch.ready) begin
			got = digest_ch.data;
			words_checked++;
			if (digest_exp_q.size() == 0) begin
				$error("unexpected digest transfer: word %h index %0d", got.digest_word,
					got.word_index);
				err_count++;
			end else begin
				want = digest_exp_q.pop_front();
				if (got.digest_word !== want.digest_word) begin
					$error("digest_word: expected %h, actual %h", want.digest_word,
						got.digest_word);
					err_count++;
				end
				if (got.word_index !== want.word_index) begin
					$error("word_index: expected %0d, actual %0d", want.word_index,
						got.word_index);
					err_count++;
				end
				if (got.last_word !== want.last_word) begin
					$error("last_word: expected %0b, actual %0b", want.last_word,
						got.last_word);
					err_count++;
				end
			end
		end
		if (cyc >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d digest words outstanding", cyc,
				digest_exp_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	// drive the message channel on the falling edge
	always @(negedge clk) begin
		feed_t nxt;
		if (arst_n && (!message_ch.valid || msg_xfer)) begin
			if (feed_q.size() != 0 && feed_q[0].pause) begin
				// hold until every digest word is back
				if (digest_exp_q.size() == 0)
					nxt = feed_q.pop_front();
				message_ch.valid <= 1'b0;
			end else if (feed_q.size() == 0 || (!quiet && $urandom_range(99) < IDLE_PCT)) begin
				message_ch.valid <= 1'b0;
			end else begin
				nxt = feed_q.pop_front();
				message_ch.valid <= 1'b1;
				message_ch.data  <= nxt.item;
			end
		end
	end

	// drive digest ready; once, stall for a long stretch while the sender keeps offering
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_holding) begin
				digest_ch.ready <= 1'b0;
				if (rx_hold_left == 0) begin
					rx_holding   <= 1'b0;
					rx_hold_done <= 1'b1;
				end else begin
					rx_hold_left <= rx_hold_left - 1;
				end
			end else if (!rx_hold_done && items_taken >= HOLD_AFTER && digest_ch.valid
				&& message_ch.valid) begin
				rx_holding      <= 1'b1;
				rx_hold_left    <= HOLD_CYCLES;
				digest_ch.ready <= 1'b0;
			end else begin
				digest_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		int len;
		int pick;
		int rand_items;
		int n_msgs;
		bit tail_byte;

		message_ch.valid = 1'b0;
		message_ch.data  = '0;
		digest_ch.ready  = 1'b0;
		for (int k = 0; k < 8; k++)
			hash_st[k] = SHA_IV[k];
		for (int k = 0; k < 16; k++)
			blk_w[k] = '0;

		// empty message
		queue_item(8'h00, 1'b0, 1'b1);
		// idle items with junk data
		queue_item(8'hff, 1'b0, 1'b0);
		queue_item(8'h00, 1'b0, 1'b0);
		// "abc", closed by the last byte
		queue_item(8'h61, 1'b1, 1'b0);
		queue_item(8'h62, 1'b1, 1'b0);
		queue_item(8'h63, 1'b1, 1'b1);
		// byte extremes, closed by an end marker whose data must be ignored
		queue_item(8'hff, 1'b1, 1'b0);
		queue_item(8'h00, 1'b0, 1'b0);
		queue_item(8'h00, 1'b1, 1'b0);
		queue_item(8'h5a, 1'b1, 1'b0);
		queue_item(8'hff, 1'b0, 1'b1);
		// single-byte messages
		queue_item(8'h00, 1'b1, 1'b1);
		queue_item(8'hff, 1'b1, 1'b1);
		queue_pause();

		// random messages: mostly short, some at the padding boundaries, a few long
		rand_items = 0;
		n_msgs     = 0;
		while (rand_items < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 55)
				len = $urandom_range(12);
			else if (pick < 85)
				len = BOUNDARY_LEN[$urandom_range(7)];
			else
				len = $urandom_range(130);
			tail_byte = (len != 0) && ($urandom_range(1) == 1);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < NOISE_PCT) begin
					queue_item(8'($urandom_range(255)), 1'b0, 1'b0);
					rand_items++;
				end
				queue_item(8'($urandom_range(255)), 1'b1, tail_byte && (i == len - 1));
			end
			if (!tail_byte)
				queue_item(8'($urandom_range(255)), 1'b0, 1'b1);
			rand_items += tail_byte ? len : len + 1;
			n_msgs++;
			if (n_msgs % PAUSE_EVERY == 0)
				queue_pause();
		end

		// hold reset, release it away from the active edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for the stimulus to drain and all digests to arrive
		while (feed_q.size() != 0 || message_ch.valid || digest_exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Hashed %0d messages (%0d bytes, %0d transfers in), checked %0d digest words.",
			msgs_closed, bytes_hashed, items_taken, words_checked);
		$display("Covered empty, single-byte and padding-boundary lengths under random stalls.");
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
